>>> src/cctp_pkg.sv
// ----------------------------------------------------------------------------
// CORDIC Cartesian-to-polar package
// Shared types, fixed-point widths and the arctangent table.
// ----------------------------------------------------------------------------
package cctp_pkg;

  localparam int unsigned XyWidth  = 35;
  localparam int unsigned AccWidth = 34;
  localparam int unsigned AtanEntries = 15;

  localparam logic signed [AccWidth-1:0] HalfPiQ30 = 34'sh06487ED51;
  localparam logic signed [31:0]         GainQ30   = 32'sh26DD3B6A;

  typedef struct packed {
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
  } cctp_in_t;

  typedef struct packed {
    logic        [15:0] magnitude;
    logic signed [15:0] angle;
  } cctp_out_t;

  typedef struct packed {
    logic signed [XyWidth-1:0]  x;
    logic signed [XyWidth-1:0]  y;
    logic signed [AccWidth-1:0] acc;
  } cctp_vec_t;

  function automatic logic signed [AccWidth-1:0] atan_entry(input logic [3:0] idx);
    logic signed [AccWidth-1:0] val;
    case (idx)
      4'd0:    val = 34'sh03243F6A8;
      4'd1:    val = 34'sh01DAC6705;
      4'd2:    val = 34'sh00FADBAFC;
      4'd3:    val = 34'sh007F56EA6;
      4'd4:    val = 34'sh003FEAB76;
      4'd5:    val = 34'sh001FFD55B;
      4'd6:    val = 34'sh000FFFAAA;
      4'd7:    val = 34'sh0007FFF55;
      4'd8:    val = 34'sh0003FFFEA;
      4'd9:    val = 34'sh0001FFFFD;
      4'd10:   val = 34'sh0000FFFFF;
      4'd11:   val = 34'sh00007FFFF;
      4'd12:   val = 34'sh00003FFFF;
      4'd13:   val = 34'sh00001FFFF;
      4'd14:   val = 34'sh00000FFFF;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

>>> src/cctp_prerot.sv
// ----------------------------------------------------------------------------
// CORDIC pre-rotation stage
// Turns points in quadrants II and III into I or IV and seeds the angle.
// ----------------------------------------------------------------------------
module cctp_prerot (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                valid_i,
  input  cctp_pkg::cctp_in_t  data_i,
  output logic                valid_o,
  output cctp_pkg::cctp_vec_t vec_o
);
  import cctp_pkg::*;

  logic signed [XyWidth-1:0] x_ext, y_ext;
  cctp_vec_t                 vec_d, vec_q;
  logic                      valid_q;

  assign x_ext = XyWidth'($signed({data_i.coord_x, 16'h0000}));
  assign y_ext = XyWidth'($signed({data_i.coord_y, 16'h0000}));

  always_comb begin
    vec_d.x   = x_ext;
    vec_d.y   = y_ext;
    vec_d.acc = '0;
    if (x_ext < 0) begin
      if (y_ext > 0) begin
        vec_d.x   = y_ext;
        vec_d.y   = -x_ext;
        vec_d.acc = -HalfPiQ30;
      end else begin
        vec_d.x   = -y_ext;
        vec_d.y   = x_ext;
        vec_d.acc = HalfPiQ30;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

>>> src/cctp_stage.sv
// ----------------------------------------------------------------------------
// CORDIC micro-rotation stage
// One vectoring step steered by the sign of y, with a fixed shift.
// ----------------------------------------------------------------------------
module cctp_stage #(
  parameter int unsigned SHIFT = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                valid_i,
  input  cctp_pkg::cctp_vec_t vec_i,
  output logic                valid_o,
  output cctp_pkg::cctp_vec_t vec_o
);
  import cctp_pkg::*;

  logic signed [XyWidth-1:0]  xs, ys;
  logic signed [AccWidth-1:0] atan_val;
  cctp_vec_t                  vec_d, vec_q;
  logic                       valid_q;

  assign xs       = vec_i.x >>> SHIFT;
  assign ys       = vec_i.y >>> SHIFT;
  assign atan_val = atan_entry(4'(SHIFT));

  always_comb begin
    if (vec_i.y >= 0) begin
      vec_d.x   = vec_i.x + ys;
      vec_d.y   = vec_i.y - xs;
      vec_d.acc = vec_i.acc - atan_val;
    end else begin
      vec_d.x   = vec_i.x - ys;
      vec_d.y   = vec_i.y + xs;
      vec_d.acc = vec_i.acc + atan_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

>>> src/cctp_post.sv
// ----------------------------------------------------------------------------
// CORDIC output stages
// Gain correction multiply, then rounding and saturation of both fields.
// ----------------------------------------------------------------------------
module cctp_post (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                valid_i,
  input  cctp_pkg::cctp_vec_t vec_i,
  output logic                valid_o,
  output cctp_pkg::cctp_out_t data_o
);
  import cctp_pkg::*;

  localparam int unsigned ProdWidth = XyWidth + 32;

  logic signed [ProdWidth-1:0] prod_d, prod_q;
  logic                        pos_d, pos_q;
  logic signed [AccWidth-1:0]  acc_q;
  logic                        valid1_q, valid2_q;

  logic        [ProdWidth-1:0] prod_rnd;
  logic        [19:0]          mag_wide;
  logic signed [AccWidth:0]    ang_rnd;
  logic signed [17:0]          ang_wide;
  cctp_out_t                   out_d, out_q;

  assign prod_d = ProdWidth'(vec_i.x) * ProdWidth'(GainQ30);
  assign pos_d  = (vec_i.x > 0);

  assign prod_rnd = unsigned'(prod_q) + (ProdWidth'(1) << 45);
  assign mag_wide = prod_rnd[65:46];
  assign ang_rnd  = -(AccWidth+1)'(acc_q) + (AccWidth+1)'(65536);
  assign ang_wide = 18'(ang_rnd >>> 17);

  always_comb begin
    if (!pos_q) begin
      out_d.magnitude = '0;
    end else if (mag_wide > 20'd65535) begin
      out_d.magnitude = 16'hFFFF;
    end else begin
      out_d.magnitude = mag_wide[15:0];
    end
    if (ang_wide > 18'sd32767) begin
      out_d.angle = 16'sh7FFF;
    end else if (ang_wide < -18'sd32768) begin
      out_d.angle = 16'sh8000;
    end else begin
      out_d.angle = ang_wide[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else if (adv_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= prod_d;
      pos_q  <= pos_d;
      acc_q  <= vec_i.acc;
      out_q  <= out_d;
    end
  end

  assign valid_o = valid2_q;
  assign data_o  = out_q;

endmodule

>>> src/cordic_cartesian_to_polar.sv
// ----------------------------------------------------------------------------
// CORDIC Cartesian-to-polar converter
// Vectoring-mode CORDIC that turns (x, y) into magnitude and angle.
// ----------------------------------------------------------------------------
// The input channel carries a point (coord_x, coord_y) in signed Q2.14. The
// output channel carries its magnitude in unsigned Q2.14 and its angle in
// radians in signed Q3.13. Both channels use valid and stall; a transfer
// happens on a rising edge with valid high and stall low.
// Every transfer in yields exactly one transfer out, in order.
// The pipeline is one pre-rotation stage, one stage per micro-rotation and
// two output stages (gain multiply, then rounding). One point may enter in
// every cycle while in_stall_o is low; throughput is one result per cycle
// while the receiver does not stall.
// Reset clears all valid bits; the data registers are not reset.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall_o is raised, so no item is lost or repeated.
// ----------------------------------------------------------------------------
module cordic_cartesian_to_polar #(
  parameter int unsigned ITERATIONS = 11
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cctp_pkg::cctp_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cctp_pkg::cctp_out_t out_data_o
);
  import cctp_pkg::*;

  logic      adv;
  logic      valid_s [ITERATIONS+1];
  cctp_vec_t vec_s   [ITERATIONS+1];

  assign in_stall_o = out_valid_o & out_stall_i;
  assign adv        = ~in_stall_o;

  cctp_prerot u_prerot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (valid_s[0]),
    .vec_o   (vec_s[0])
  );

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_stage
    cctp_stage #(
      .SHIFT (i)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (valid_s[i]),
      .vec_i   (vec_s[i]),
      .valid_o (valid_s[i+1]),
      .vec_o   (vec_s[i+1])
    );
  end

  cctp_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (valid_s[ITERATIONS]),
    .vec_i   (vec_s[ITERATIONS]),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the CORDIC Cartesian-to-polar converter
// A short table of corner points comes first, then about two thousand random
// points. The sender works in bursts and the receiver stalls on its own
// pattern. Every result is compared field by field; the origin with its fixed
// value, the rest with a bit-exact vectoring-mode CORDIC in the testbench.
// ----------------------------------------------------------------------------
module tb_top;
  import cctp_pkg::*;

  localparam int          Iterations  = 11;
  localparam int          NumDirected = 23;
  localparam int          NumRandom   = 1950;
  localparam int          PauseAt     = NumDirected + NumRandom / 2;
  localparam int          DrainCycles = 40;
  localparam longint      HalfPiQ30   = 64'sh6487ED51;
  localparam longint      GainQ30     = 64'sh26DD3B6A;

  typedef struct packed {
    cctp_in_t  pt;
    logic      fixed;
    cctp_out_t res;
  } point_row_t;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  cctp_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  cctp_out_t out_data_o;

  cctp_out_t pending_polar [$];
  int        mismatches = 0;

  // The origin has a known result: zero length and the sum of the used
  // arctangent entries as angle.
  point_row_t corner_points [NumDirected] = '{
    {16'h0000, 16'h0000, 1'b1, 16'd0, 16'd14273},
    {16'h7FFF, 16'h7FFF, 1'b0, 16'd0, 16'd0},
    {16'h8000, 16'h8000, 1'b0, 16'd0, 16'd0},
    {16'h8000, 16'h7FFF, 1'b0, 16'd0, 16'd0},
    {16'h7FFF, 16'h8000, 1'b0, 16'd0, 16'd0},
    {16'h8000, 16'h0000, 1'b0, 16'd0, 16'd0},
    {16'hC000, 16'h0000, 1'b0, 16'd0, 16'd0},
    {16'hFFFF, 16'h0000, 1'b0, 16'd0, 16'd0},
    {16'h4000, 16'h0000, 1'b0, 16'd0, 16'd0},
    {16'h7FFF, 16'h0000, 1'b0, 16'd0, 16'd0},
    {16'h0000, 16'h7FFF, 1'b0, 16'd0, 16'd0},
    {16'h0000, 16'h8000, 1'b0, 16'd0, 16'd0},
    {16'h0000, 16'h4000, 1'b0, 16'd0, 16'd0},
    {16'h0000, 16'hC000, 1'b0, 16'd0, 16'd0},
    {16'h0001, 16'h0000, 1'b0, 16'd0, 16'd0},
    {16'h0000, 16'h0001, 1'b0, 16'd0, 16'd0},
    {16'h0000, 16'hFFFF, 1'b0, 16'd0, 16'd0},
    {16'hFFFF, 16'hFFFF, 1'b0, 16'd0, 16'd0},
    {16'hFFFF, 16'h0001, 1'b0, 16'd0, 16'd0},
    {16'h0001, 16'hFFFF, 1'b0, 16'd0, 16'd0},
    {16'h4000, 16'h4000, 1'b0, 16'd0, 16'd0},
    {16'hC000, 16'h4000, 1'b0, 16'd0, 16'd0},
    {16'hC000, 16'hC000, 1'b0, 16'd0, 16'd0}
  };

  cordic_cartesian_to_polar dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  function automatic longint atan_q30(int idx);
    case (idx)
      0:       return 64'sh3243F6A8;
      1:       return 64'sh1DAC6705;
      2:       return 64'sh0FADBAFC;
      3:       return 64'sh07F56EA6;
      4:       return 64'sh03FEAB76;
      5:       return 64'sh01FFD55B;
      6:       return 64'sh00FFFAAA;
      7:       return 64'sh007FFF55;
      8:       return 64'sh003FFFEA;
      9:       return 64'sh001FFFFD;
      10:      return 64'sh000FFFFF;
      11:      return 64'sh0007FFFF;
      12:      return 64'sh0003FFFF;
      13:      return 64'sh0001FFFF;
      14:      return 64'sh0000FFFF;
      default: return 64'sh0;
    endcase
  endfunction

  function automatic cctp_out_t polar_of(cctp_in_t p);
    longint            xv;
    longint            yv;
    longint            tv;
    longint            xs;
    longint            ys;
    longint            acc;
    longint            angv;
    longint unsigned   prod;
    longint unsigned   magv;
    int                i;
    cctp_out_t         r;
    xv  = longint'(p.coord_x) * 65536;
    yv  = longint'(p.coord_y) * 65536;
    acc = 0;
    if (xv < 0) begin
      tv = xv;
      if (yv > 0) begin
        xv  = yv;
        yv  = -tv;
        acc = -HalfPiQ30;
      end else begin
        xv  = -yv;
        yv  = tv;
        acc = HalfPiQ30;
      end
    end
    for (i = 0; i < Iterations && i < 15; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (yv >= 0) begin
        xv  = xv + ys;
        yv  = yv - xs;
        acc = acc - atan_q30(i);
      end else begin
        xv  = xv - ys;
        yv  = yv + xs;
        acc = acc + atan_q30(i);
      end
    end
    if (xv <= 0) begin
      magv = 0;
    end else begin
      prod = longint'(xv) * longint'(GainQ30);
      magv = (prod + (64'd1 << 45)) >> 46;
      if (magv > 64'd65535) magv = 64'd65535;
    end
    angv = (-acc + 64'sd65536) >>> 17;
    if (angv > 32767) angv = 32767;
    if (angv < -32768) angv = -32768;
    r.magnitude = magv[15:0];
    r.angle     = angv[15:0];
    return r;
  endfunction

  function automatic logic [15:0] corner_value();
    case ($urandom_range(0, 6))
      0:       return 16'h8000;
      1:       return 16'h8001;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      4:       return 16'h0001;
      5:       return 16'h7FFE;
      default: return 16'h7FFF;
    endcase
  endfunction

  function automatic cctp_in_t random_point();
    cctp_in_t p;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        p.coord_x = 16'($urandom_range(0, 65535));
        p.coord_y = 16'($urandom_range(0, 65535));
      end
      4, 5: begin
        p.coord_x = 16'($signed($urandom_range(0, 128)) - 64);
        p.coord_y = 16'($signed($urandom_range(0, 128)) - 64);
      end
      6: begin
        p.coord_x = 16'($urandom_range(0, 65535));
        p.coord_y = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
        if ($urandom_range(0, 1)) begin
          p.coord_y = p.coord_x;
          p.coord_x = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
        end
      end
      7: begin
        p.coord_x = corner_value();
        p.coord_y = corner_value();
      end
      default: begin
        p.coord_x = 16'($signed($urandom_range(0, 32768)) - 16384);
        p.coord_y = 16'($signed($urandom_range(0, 32768)) - 16384);
      end
    endcase
    return p;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #500_000;
    $display("cordic_cartesian_to_polar: mismatch");
    $finish;
  end

  // The receiver switches between four stall patterns, picked at random.
  initial begin : receiver_stall
    int          stall_mode;
    logic [31:0] cycle_cnt;
    stall_mode = 0;
    cycle_cnt  = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt % 97 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= (cycle_cnt[2:0] < 3'd3);
      endcase
    end
  end

  // A result transfer happens at the next rising edge when valid is high and
  // stall is low at the falling edge before it.
  always @(negedge clk_i) begin
    cctp_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_polar.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: magnitude %0d angle %0d",
                   out_data_o.magnitude, out_data_o.angle);
      end else begin
        want = pending_polar.pop_front();
        if (out_data_o.magnitude !== want.magnitude || out_data_o.angle !== want.angle) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result differs: magnitude %0d (expected %0d) angle %0d (expected %0d)",
                     out_data_o.magnitude, want.magnitude,
                     out_data_o.angle, want.angle);
        end
      end
    end
  end

  initial begin : sender
    int        n;
    int        gap_len;
    int        burst_left;
    logic      taken;
    cctp_in_t  pt;
    cctp_out_t want;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst_left = 0;
    for (n = 0; n < NumDirected + NumRandom; n++) begin
      if (n < NumDirected) begin
        pt   = corner_points[n].pt;
        want = corner_points[n].fixed ? corner_points[n].res : polar_of(pt);
      end else begin
        pt   = random_point();
        want = polar_of(pt);
      end
      if (burst_left == 0) begin
        gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 12);
        if (gap_len > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap_len) @(posedge clk_i);
        end
      end
      if (n == PauseAt) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (pending_polar.size() != 0);
      end
      in_valid_i <= 1'b1;
      in_data_i  <= pt;
      do begin
        @(negedge clk_i);
        taken = !in_stall_o;
        if (taken) pending_polar.push_back(want);
        @(posedge clk_i);
      end while (!taken);
      burst_left--;
    end
    in_valid_i <= 1'b0;
    while (pending_polar.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_polar.size() == 0) begin
      $display("cordic_cartesian_to_polar: match");
    end else begin
      $display("cordic_cartesian_to_polar: mismatch");
    end
    $finish;
  end

endmodule
